// ===== rtl/core/swms_pkg.sv =====
// shared types and constants for the mass-spring string stepper
`timescale 1ns / 1ps
package swms_pkg;

  localparam int MAX_MASSES_DEF = 128;
  localparam int VALUE_BITS_DEF = 24;

  localparam int CELL_IDX_BITS = 7;
  localparam int CELL_BITS     = 24;
  localparam int OUT_BITS      = 24;
  localparam int COUNT_BITS    = 8;
  localparam int OUTIDX_BITS   = 7;
  localparam int GAIN_BITS     = 24;
  localparam int GAIN_FRAC     = 24;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = 1;

  localparam logic [COUNT_BITS-1:0] MASS_COUNT_RST = 8'd100;

  localparam logic signed [OUT_BITS-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = -24'sh800000;

  localparam logic ACTION_TICK = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_MASS_COUNT   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUTPUT_INDEX = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COUPLING     = 2'd2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  // head of the queue as the back end sees it
  typedef struct packed {
    logic valid;
    op_t  op;
  } item_ctl_t;

  // back end status seen by the front end
  typedef struct packed {
    logic clearing;
    logic take;
  } back_stat_t;

endpackage

// ===== rtl/core/swms_front.sv =====
// request intake: classify, clip written values, two-entry queue to the back end
`timescale 1ns / 1ps
module swms_front #(
  parameter int MAX_MASSES = swms_pkg::MAX_MASSES_DEF,
  parameter int VALUE_BITS = swms_pkg::VALUE_BITS_DEF,
  localparam int AW = $clog2(MAX_MASSES),
  localparam int CW = (AW + 1 > 8) ? AW + 1 : 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic                                   action,
  input  logic [swms_pkg::CELL_IDX_BITS-1:0]     cell_index,
  input  logic signed [swms_pkg::CELL_BITS-1:0]  cell_value,
  output logic                                   busy,
  input  swms_pkg::back_stat_t                   stat,
  output swms_pkg::item_ctl_t                    item,
  output logic [AW-1:0]                          item_addr,
  output logic signed [VALUE_BITS-1:0]           item_val
);
  import swms_pkg::*;

  localparam int EW = (VALUE_BITS > CELL_BITS) ? VALUE_BITS : CELL_BITS;
  localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  op_t                          q_op   [Q_DEPTH];
  logic [AW-1:0]                q_addr [Q_DEPTH];
  logic signed [VALUE_BITS-1:0] q_val  [Q_DEPTH];
  logic [Q_PTR_BITS-1:0]        wp;
  logic [Q_PTR_BITS-1:0]        rp;
  logic [Q_PTR_BITS:0]          q_cnt;

  logic                         accept;
  logic                         push;
  logic                         pop;
  logic                         is_tick;
  logic [CW-1:0]                idx_ext;
  logic                         idx_ok;
  logic signed [EW-1:0]         cv_ext;
  logic signed [VALUE_BITS-1:0] val_clip;

  assign busy    = stat.clearing || (q_cnt == (Q_PTR_BITS+1)'(Q_DEPTH));
  assign accept  = start && !busy;
  assign is_tick = (action == ACTION_TICK);
  assign idx_ext = CW'(cell_index);
  assign idx_ok  = idx_ext < CW'(MAX_MASSES);
  // writes past the end of the store are dropped here
  assign push    = accept && (is_tick || idx_ok);
  assign pop     = stat.take;

  assign cv_ext = EW'(cell_value);

  always_comb begin
    priority if (cv_ext > EW'(VMAX)) begin
      val_clip = VMAX;
    end else if (cv_ext < EW'(VMIN)) begin
      val_clip = VMIN;
    end else begin
      val_clip = cv_ext[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      q_cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      q_cnt <= q_cnt + (Q_PTR_BITS+1)'(push) - (Q_PTR_BITS+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wp]   <= is_tick ? OP_TICK : OP_WRITE;
      q_addr[wp] <= idx_ext[AW-1:0];
      q_val[wp]  <= val_clip;
    end
  end

  assign item.valid = (q_cnt != '0);
  assign item.op    = q_op[rp];
  assign item_addr  = q_addr[rp];
  assign item_val   = q_val[rp];

endmodule

// ===== rtl/core/swms_back.sv =====
// execution: state memory, clearing pass, streamed tick pipeline, result register
`timescale 1ns / 1ps
module swms_back #(
  parameter int MAX_MASSES = swms_pkg::MAX_MASSES_DEF,
  parameter int VALUE_BITS = swms_pkg::VALUE_BITS_DEF,
  localparam int AW = $clog2(MAX_MASSES),
  localparam int CW = (AW + 1 > 8) ? AW + 1 : 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [CW-1:0]                         cnt,
  input  logic [swms_pkg::OUTIDX_BITS-1:0]      output_index,
  input  logic [swms_pkg::GAIN_BITS-1:0]        coupling_gain,
  input  swms_pkg::item_ctl_t                   item,
  input  logic [AW-1:0]                         item_addr,
  input  logic signed [VALUE_BITS-1:0]          item_val,
  output swms_pkg::back_stat_t                  stat,
  output logic                                  done,
  output logic signed [swms_pkg::OUT_BITS-1:0]  sample,
  output logic                                  saturated
);
  import swms_pkg::*;

  localparam int VB  = VALUE_BITS;
  localparam int LW  = VB + 2;                 // laplacian
  localparam int PW  = LW + GAIN_BITS + 1;     // gain product
  localparam int DW  = PW - GAIN_FRAC;         // rounded delta
  localparam int SW  = DW + 1;                 // velocity sum
  localparam int EWO = (VB > OUT_BITS) ? VB : OUT_BITS;
  localparam int MW  = 2 * VB;

  localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};
  localparam logic signed [PW-1:0] HALF =
    {{(PW-GAIN_FRAC){1'b0}}, 1'b1, {(GAIN_FRAC-1){1'b0}}};
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_MASSES - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_TICK  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;
  localparam logic [2:0] ST_OUTW  = 3'd5;

  // velocity in the upper half, position in the lower half
  logic [MW-1:0] mem [MAX_MASSES];
  logic [MW-1:0] rd_q;

  logic [2:0]    state;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] rd_tag;
  logic          rd_v;
  logic          sat;

  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] tick_last;
  logic [CW-1:0] oi_ext;
  logic          out_ok;
  logic          rd_en;
  logic [AW-1:0] rd_sel;
  logic          we;
  logic [AW-1:0] wa;
  logic [MW-1:0] wd;

  logic signed [VB-1:0] pos_q;
  logic signed [VB-1:0] vel_q;

  // sliding window of pre-tick positions
  logic signed [VB-1:0] w0;
  logic signed [VB-1:0] w1;
  logic signed [VB-1:0] vprev;

  logic                 lap_v;
  logic signed [LW-1:0] lap;
  logic signed [VB-1:0] lap_cur;
  logic signed [VB-1:0] lap_vel;
  logic [AW-1:0]        lap_idx;

  logic                 prd_v;
  logic signed [PW-1:0] prd;
  logic signed [VB-1:0] prd_cur;
  logic signed [VB-1:0] prd_vel;
  logic [AW-1:0]        prd_idx;

  logic                 dlt_v;
  logic signed [DW-1:0] dlt;
  logic signed [VB-1:0] dlt_cur;
  logic signed [VB-1:0] dlt_vel;
  logic [AW-1:0]        dlt_idx;

  logic                 vnw_v;
  logic signed [VB-1:0] vnw_vel;
  logic                 vnw_sat;
  logic signed [VB-1:0] vnw_cur;
  logic [AW-1:0]        vnw_idx;

  logic signed [LW-1:0]     lap_new;
  logic signed [PW-1:0]     gain_s;
  logic signed [PW-1:0]     rnd;
  logic signed [SW-1:0]     vsum;
  logic signed [VB-1:0]     vclip;
  logic                     vclip_hit;
  logic signed [VB:0]       psum;
  logic signed [VB-1:0]     pclip;
  logic                     pclip_hit;
  logic signed [EWO-1:0]    res_ext;
  logic signed [OUT_BITS-1:0] res_clip;
  logic                     res_hit;
  logic                     pipe_busy;

  assign pos_q = rd_q[VB-1:0];
  assign vel_q = rd_q[MW-1:VB];

  assign cnt_m1    = cnt - CW'(1);
  assign tick_last = cnt_m1[AW-1:0];
  assign oi_ext    = CW'(output_index);
  assign out_ok    = oi_ext < CW'(MAX_MASSES);

  assign stat.clearing = (state == ST_CLEAR);
  assign stat.take     = (state == ST_IDLE) && item.valid;

  assign pipe_busy = rd_v || lap_v || prd_v || dlt_v || vnw_v;

  assign rd_en  = (state == ST_TICK) || (state == ST_OUT);
  assign rd_sel = (state == ST_TICK) ? rd_addr : oi_ext[AW-1:0];

  // old_left - 2*cur + right, all pre-tick values
  assign lap_new = LW'(w0) - (LW'(w1) <<< 1) + LW'(pos_q);
  assign gain_s  = PW'($signed({1'b0, coupling_gain}));
  assign rnd     = prd + HALF;

  assign vsum = SW'(dlt_vel) + SW'(dlt);
  always_comb begin
    vclip_hit = 1'b1;
    priority if (vsum > SW'(VMAX)) begin
      vclip = VMAX;
    end else if (vsum < SW'(VMIN)) begin
      vclip = VMIN;
    end else begin
      vclip     = vsum[VB-1:0];
      vclip_hit = 1'b0;
    end
  end

  assign psum = (VB+1)'(vnw_cur) + (VB+1)'(vnw_vel);
  always_comb begin
    pclip_hit = 1'b1;
    priority if (psum > (VB+1)'(VMAX)) begin
      pclip = VMAX;
    end else if (psum < (VB+1)'(VMIN)) begin
      pclip = VMIN;
    end else begin
      pclip     = psum[VB-1:0];
      pclip_hit = 1'b0;
    end
  end

  assign res_ext = out_ok ? EWO'(pos_q) : '0;
  always_comb begin
    res_hit = 1'b1;
    priority if (res_ext > EWO'(OUT_MAX)) begin
      res_clip = OUT_MAX;
    end else if (res_ext < EWO'(OUT_MIN)) begin
      res_clip = OUT_MIN;
    end else begin
      res_clip = res_ext[OUT_BITS-1:0];
      res_hit  = 1'b0;
    end
  end

  always_comb begin
    we = 1'b0;
    wa = clr_addr;
    wd = '0;
    priority if (state == ST_CLEAR) begin
      we = 1'b1;
    end else if (stat.take && item.op == OP_WRITE) begin
      we = 1'b1;
      wa = item_addr;
      wd = {{VB{1'b0}}, item_val};
    end else if (vnw_v) begin
      we = 1'b1;
      wa = vnw_idx;
      wd = {vnw_vel, pclip};
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      rd_addr  <= '0;
      rd_v     <= 1'b0;
      lap_v    <= 1'b0;
      prd_v    <= 1'b0;
      dlt_v    <= 1'b0;
      vnw_v    <= 1'b0;
      sat      <= 1'b0;
      done     <= 1'b0;
    end else begin
      done  <= 1'b0;
      rd_v  <= 1'b0;
      lap_v <= rd_v && (rd_tag >= AW'(2));
      prd_v <= lap_v;
      dlt_v <= prd_v;
      vnw_v <= dlt_v;
      if (vnw_v && (vnw_sat || pclip_hit)) begin
        sat <= 1'b1;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (stat.take && item.op == OP_TICK) begin
            sat     <= 1'b0;
            rd_addr <= '0;
            // fewer than three masses: nothing moves
            state   <= (cnt < CW'(3)) ? ST_OUT : ST_TICK;
          end
        end
        ST_TICK: begin
          rd_v    <= 1'b1;
          rd_addr <= rd_addr + 1'b1;
          if (rd_addr == tick_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!pipe_busy) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          state <= ST_OUTW;
        end
        ST_OUTW: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_tag <= rd_addr;
    if (rd_v) begin
      w0      <= w1;
      w1      <= pos_q;
      vprev   <= vel_q;
      lap     <= lap_new;
      lap_cur <= w1;
      lap_vel <= vprev;
      lap_idx <= rd_tag - AW'(1);
    end
    prd     <= gain_s * PW'(lap);
    prd_cur <= lap_cur;
    prd_vel <= lap_vel;
    prd_idx <= lap_idx;

    // floor of the rounded product, upper bits only
    dlt     <= rnd[PW-1:GAIN_FRAC];
    dlt_cur <= prd_cur;
    dlt_vel <= prd_vel;
    dlt_idx <= prd_idx;

    vnw_vel <= vclip;
    vnw_sat <= vclip_hit;
    vnw_cur <= dlt_cur;
    vnw_idx <= dlt_idx;

    if (state == ST_OUTW) begin
      sample    <= res_clip;
      saturated <= sat || res_hit;
    end
  end

endmodule

// ===== rtl/core/string_mass_spring_wave_step.sv =====
// top level of the mass-spring string stepper
//
//   channel  | handshake        | payload
//   ---------+------------------+---------------------------------
//   request  | start / busy     | action, cell_index, cell_value
//   result   | done (strobe)    | sample, saturated
//   config   | wr_en            | wr_index, wr_data
//
// a write request goes straight into the state memory as the back end takes
// it; a tick streams the masses through the single read port of the state memory
// one mass per cycle, and then through the five-stage update pipeline.
// after reset a clearing pass over all MAX_MASSES cells holds busy high.
// busy also rises while the two-entry request queue is full.
// done is high for one cycle per tick; the receiver cannot stall.
`timescale 1ns / 1ps
module string_mass_spring_wave_step #(
  parameter int MAX_MASSES = swms_pkg::MAX_MASSES_DEF,
  parameter int VALUE_BITS = swms_pkg::VALUE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  action,
  input  logic [swms_pkg::CELL_IDX_BITS-1:0]    cell_index,
  input  logic signed [swms_pkg::CELL_BITS-1:0] cell_value,
  output logic                                  done,
  output logic signed [swms_pkg::OUT_BITS-1:0]  sample,
  output logic                                  saturated,
  input  logic                                  wr_en,
  input  logic [swms_pkg::CFG_IDX_BITS-1:0]     wr_index,
  input  logic [swms_pkg::CFG_DATA_BITS-1:0]    wr_data
);
  import swms_pkg::*;

  localparam int AW = $clog2(MAX_MASSES);
  localparam int CW = (AW + 1 > 8) ? AW + 1 : 8;

  logic [COUNT_BITS-1:0]  mass_count;
  logic [OUTIDX_BITS-1:0] output_index;
  logic [GAIN_BITS-1:0]   coupling_gain;
  logic [CW-1:0]          cnt_ext;
  logic [CW-1:0]          cnt;

  item_ctl_t                    item;
  back_stat_t                   stat;
  logic [AW-1:0]                item_addr;
  logic signed [VALUE_BITS-1:0] item_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      mass_count    <= MASS_COUNT_RST;
      output_index  <= '0;
      coupling_gain <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MASS_COUNT:   mass_count    <= wr_data[COUNT_BITS-1:0];
        REG_OUTPUT_INDEX: output_index  <= wr_data[OUTIDX_BITS-1:0];
        REG_COUPLING:     coupling_gain <= wr_data[GAIN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // counts above the store size use the whole store
  assign cnt_ext = CW'(mass_count);
  assign cnt     = (cnt_ext > CW'(MAX_MASSES)) ? CW'(MAX_MASSES) : cnt_ext;

  swms_front #(
    .MAX_MASSES (MAX_MASSES),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .action     (action),
    .cell_index (cell_index),
    .cell_value (cell_value),
    .busy       (busy),
    .stat       (stat),
    .item       (item),
    .item_addr  (item_addr),
    .item_val   (item_val)
  );

  swms_back #(
    .MAX_MASSES (MAX_MASSES),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cnt           (cnt),
    .output_index  (output_index),
    .coupling_gain (coupling_gain),
    .item          (item),
    .item_addr     (item_addr),
    .item_val      (item_val),
    .stat          (stat),
    .done          (done),
    .sample        (sample),
    .saturated     (saturated)
  );

endmodule

// ===== rtl/core/swms_checker.sv =====
// port-level checks for the string stepper, bound to the top level
`timescale 1ns / 1ps
module swms_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic action,
  input logic done
);
  import swms_pkg::*;

  // ticks accepted whose result has not been seen yet
  logic [1:0] pending;
  logic       tick_in;

  assign tick_in = start && !busy && (action == ACTION_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(tick_in) - 2'(done);
    end
  end

  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("two result strobes in a row");

  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> (pending != 2'd0))
    else $error("result without an outstanding tick request");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    tick_in |-> (pending != 2'd3))
    else $error("tick request accepted with queue and back end full");

endmodule

bind string_mass_spring_wave_step swms_checker u_swms_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .action (action),
  .done   (done)
);

// ===== dv/string_mass_spring_wave_step_tb.sv =====
// testbench for the mass-spring string stepper: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module string_mass_spring_wave_step_tb;
  import swms_pkg::*;

  localparam int MASSES       = MAX_MASSES_DEF;
  localparam int VBITS        = VALUE_BITS_DEF;
  localparam int QUIET_CYCLES = MASSES + 24;
  localparam int RANDOM_ITEMS = 650;
  localparam longint VAL_HI   = (longint'(1) << (VBITS - 1)) - 1;
  localparam longint VAL_LO   = -VAL_HI - 1;

  typedef struct {
    logic signed [OUT_BITS-1:0] sample;
    logic                       saturated;
  } tick_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic                        action = 1'b0;
  logic [CELL_IDX_BITS-1:0]    cell_index = '0;
  logic signed [CELL_BITS-1:0] cell_value = '0;
  logic                        done;
  logic signed [OUT_BITS-1:0]  sample;
  logic                        saturated;
  logic                        wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0]     wr_index = '0;
  logic [CFG_DATA_BITS-1:0]    wr_data = '0;

  // predictor state and register copies
  logic signed [VBITS-1:0] disp_model [MASSES];
  logic signed [VBITS-1:0] vel_model [MASSES];
  logic [COUNT_BITS-1:0]   cfg_masses;
  logic [OUTIDX_BITS-1:0]  cfg_tap;
  logic [GAIN_BITS-1:0]    cfg_gain;
  logic                    clip_seen;

  tick_result_t expected_samples [$];
  tick_result_t head;
  int           errors = 0;
  int           items_sent = 0;
  bit           steady_request = 1'b0;

  string_mass_spring_wave_step dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .cell_index (cell_index),
    .cell_value (cell_value),
    .done       (done),
    .sample     (sample),
    .saturated  (saturated),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_error(string what, longint got, longint want);
    $display("error at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic longint clip_store(longint x);
    if (x > VAL_HI) begin
      clip_seen = 1'b1;
      return VAL_HI;
    end
    if (x < VAL_LO) begin
      clip_seen = 1'b1;
      return VAL_LO;
    end
    return x;
  endfunction

  task automatic reset_string_model();
    int i;
    for (i = 0; i < MASSES; i++) begin
      disp_model[i] = '0;
      vel_model[i] = '0;
    end
    cfg_masses = MASS_COUNT_RST;
    cfg_tap = '0;
    cfg_gain = '0;
  endtask

  // one semi-implicit euler step; laplacian uses pre-tick neighbors
  task automatic step_string_model();
    int n, i;
    longint left, cur, right, lap, delta, vnew, pnew;
    tick_result_t r;
    n = (cfg_masses > MASSES) ? MASSES : cfg_masses;
    clip_seen = 1'b0;
    if (n >= 3) begin
      left = disp_model[0];
      for (i = 1; i + 1 < n; i++) begin
        cur = disp_model[i];
        right = disp_model[i + 1];
        lap = left - 2 * cur + right;
        delta = (longint'(cfg_gain) * lap + (longint'(1) << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
        vnew = clip_store(longint'(vel_model[i]) + delta);
        vel_model[i] = vnew[VBITS-1:0];
        left = cur;
        pnew = clip_store(cur + vnew);
        disp_model[i] = pnew[VBITS-1:0];
      end
    end
    r.sample = disp_model[cfg_tap];
    r.saturated = clip_seen;
    expected_samples.push_back(r);
  endtask

  task automatic send_request(op_t op, logic [CELL_IDX_BITS-1:0] idx,
                              logic signed [CELL_BITS-1:0] val);
    // idle cycles drawn one at a time
    while (!steady_request && $urandom_range(0, 99) < 27) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    action <= op;
    cell_index <= idx;
    cell_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_TICK) begin
      step_string_model();
    end else begin
      disp_model[idx] = val;
      vel_model[idx] = '0;
    end
    items_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (expected_samples.size() != 0);
    // a write request may still sit behind the last tick
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic pause_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (expected_samples.size() != 0);
  endtask

  task automatic apply_setting(logic [COUNT_BITS-1:0] masses, logic [OUTIDX_BITS-1:0] tap,
                               logic [GAIN_BITS-1:0] gain);
    wait_idle();
    wr_en <= 1'b1;
    wr_index <= REG_MASS_COUNT;
    wr_data <= {16'd0, masses};
    @(posedge clk);
    wr_index <= REG_OUTPUT_INDEX;
    wr_data <= {17'd0, tap};
    @(posedge clk);
    wr_index <= REG_COUPLING;
    wr_data <= gain;
    @(posedge clk);
    wr_en <= 1'b0;
    cfg_masses = masses;
    cfg_tap = tap;
    cfg_gain = gain;
  endtask

  function automatic logic signed [CELL_BITS-1:0] random_disp();
    logic signed [CELL_BITS-1:0] r;
    r = CELL_BITS'($urandom);
    case ($urandom_range(0, 4))
      0: return r;
      1: return r >>> 4;
      2: return r >>> 10;
      3: return ($urandom_range(0, 1) == 0) ? OUT_MAX : OUT_MIN;
      default: return r >>> 16;
    endcase
  endfunction

  // results are one-cycle strobes and cannot be held off
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_samples.size() == 0) begin
        report_error("result with no tick pending, sample", sample, 0);
      end else begin
        head = expected_samples.pop_front();
        if (sample !== head.sample) report_error("sample", sample, head.sample);
        if (saturated !== head.saturated) report_error("saturated", saturated, head.saturated);
      end
    end
  end

  task automatic test_reset_state();
    send_request(OP_TICK, '0, '0);
    send_request(OP_WRITE, 7'd0, 24'sd5);
    send_request(OP_TICK, 7'd0, '0);
  endtask

  task automatic test_saturation();
    apply_setting(8'd3, 7'd1, 24'hFFFFFF);
    send_request(OP_WRITE, 7'd0, OUT_MAX);
    send_request(OP_WRITE, 7'd1, OUT_MIN);
    send_request(OP_WRITE, 7'd2, OUT_MAX);
    send_request(OP_TICK, '0, '0);
    send_request(OP_TICK, '0, '0);
    send_request(OP_WRITE, 7'd1, -24'sd1);
    send_request(OP_TICK, '0, '0);
  endtask

  // fewer than three masses leaves nothing to move
  task automatic test_small_count();
    apply_setting(8'd2, 7'd1, 24'h800000);
    send_request(OP_WRITE, 7'd1, 24'sd1000);
    send_request(OP_TICK, '0, '0);
    apply_setting(8'd0, 7'd1, 24'hFFFFFF);
    send_request(OP_TICK, '0, '0);
  endtask

  // counts past the store size clamp to all masses
  task automatic test_large_count();
    apply_setting(8'd255, 7'd126, 24'h400000);
    send_request(OP_WRITE, 7'd127, OUT_MIN);
    send_request(OP_WRITE, 7'd126, OUT_MAX);
    send_request(OP_TICK, '0, '0);
    apply_setting(8'd128, 7'd127, 24'h400000);
    send_request(OP_TICK, '0, '0);
  endtask

  task automatic test_tap_beyond_count();
    apply_setting(8'd4, 7'd100, 24'h100000);
    send_request(OP_WRITE, 7'd100, 24'sh123456);
    send_request(OP_TICK, '0, '0);
    send_request(OP_WRITE, 7'd2, -24'sh0ABCDE);
    send_request(OP_TICK, '0, '0);
  endtask

  task automatic test_end_mass_write();
    apply_setting(8'd5, 7'd1, 24'h200000);
    send_request(OP_WRITE, 7'd0, 24'sh400000);
    send_request(OP_TICK, '0, '0);
    send_request(OP_TICK, '0, '0);
    send_request(OP_WRITE, 7'd4, -24'sh300000);
    send_request(OP_TICK, '0, '0);
  endtask

  task automatic test_random_plucks();
    int phase, n, phase_len, first, k, ticks;
    logic [COUNT_BITS-1:0]  masses;
    logic [OUTIDX_BITS-1:0] tap;
    logic [GAIN_BITS-1:0]   gain;
    first = items_sent;
    phase = 0;
    while (items_sent - first < RANDOM_ITEMS) begin
      case ($urandom_range(0, 15))
        0: masses = COUNT_BITS'($urandom_range(0, 2));
        1: masses = COUNT_BITS'($urandom_range(129, 255));
        2: masses = 8'd128;
        default: masses = COUNT_BITS'($urandom_range(3, 20));
      endcase
      n = (masses > MASSES) ? MASSES : masses;
      if (n < 3) n = 3;
      tap = ($urandom_range(0, 3) == 0) ? OUTIDX_BITS'($urandom_range(0, 127))
                                        : OUTIDX_BITS'($urandom_range(0, n - 1));
      case ($urandom_range(0, 4))
        0: gain = '0;
        1: gain = 24'hFFFFFF;
        2: gain = GAIN_BITS'($urandom);
        3: gain = GAIN_BITS'($urandom_range(0, 24'h100000));
        default: gain = GAIN_BITS'($urandom_range(0, 24'h20000));
      endcase
      apply_setting(masses, tap, gain);
      steady_request = (phase == 2);
      phase_len = (n > 64) ? $urandom_range(8, 16) : $urandom_range(30, 70);
      k = items_sent;
      while (items_sent - k < phase_len) begin
        // pluck shape first, then let it ring
        repeat ($urandom_range(1, 5))
          send_request(OP_WRITE, CELL_IDX_BITS'($urandom_range(0, n - 1)), random_disp());
        ticks = $urandom_range(3, 20);
        repeat (ticks) begin
          if ($urandom_range(0, 9) == 0)
            send_request(OP_WRITE, CELL_IDX_BITS'($urandom_range(0, 127)), random_disp());
          send_request(OP_TICK, CELL_IDX_BITS'($urandom_range(0, 127)),
                       CELL_BITS'($urandom));
        end
        if (phase == 0 || $urandom_range(0, 5) == 0) pause_until_drained();
      end
      phase++;
    end
    steady_request = 1'b0;
  endtask

  initial begin
    reset_string_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // clearing pass after reset
    do @(posedge clk); while (busy);
    test_reset_state();
    test_saturation();
    test_small_count();
    test_large_count();
    test_tap_beyond_count();
    test_end_mass_write();
    test_random_plucks();
    wait_idle();
    if (errors == 0) begin
      $display("string_mass_spring_wave_step: match");
    end else begin
      $display("string_mass_spring_wave_step: mismatch");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("string_mass_spring_wave_step: mismatch");
    $finish;
  end

endmodule
